// ===== design/pkmp_pkg.sv =====
// ----------------------------------------------------------------------------
// pkmp_pkg
// Types and constants shared by the projective key block and its core.
// ----------------------------------------------------------------------------
package pkmp_pkg;

    // width of every value field and of the modulus register
    localparam int VALUE_BITS = 63;

    // configuration register indexes (paddr[3], registers 8 bytes apart)
    localparam logic REG_PRIME = 1'b0;

    // reset value of the modulus register
    localparam logic [VALUE_BITS-1:0] PRIME_RESET = VALUE_BITS'(2);

    // input request payload
    typedef struct packed {
        logic [VALUE_BITS-1:0] u;
        logic [VALUE_BITS-1:0] v;
    } pkmp_in_t;

    // result payload
    typedef struct packed {
        logic [VALUE_BITS-1:0] key;
        logic                  both_zero;
    } pkmp_out_t;

    // top level to core
    typedef struct packed {
        logic start;
    } pkmp_ctrl_t;

    // core to top level
    typedef struct packed {
        logic busy;
        logic done;
    } pkmp_stat_t;

    // sequencer states of the core
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_MULS,
        ST_SWAP,
        ST_FIXS,
        ST_FIXR,
        ST_MMUL,
        ST_FIN
    } pkmp_state_t;

endpackage

// ===== design/projective_key_mod_prime.sv =====
// ----------------------------------------------------------------------------
// projective_key_mod_prime
// Projective key of (u:v) over the field set by the modulus register:
// v * u^-1 mod m for nonzero u and m, m itself for u zero, 0 for m zero, plus a both-zero flag.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  src       in         src_valid / src_stall         src_data (u, v)
//  res       out        res_valid / res_stall         res_data (key, both_zero)
//  apb       in/out     psel penable pwrite pready    paddr pwdata prdata
//
//  one request at a time; src_stall is high from acceptance until the result
//  has been taken.
//  reset clears the sequencer and loads modulus 2; no clearing pass.
//  a stalled result holds in the output register.
//
module projective_key_mod_prime (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  pkmp_pkg::pkmp_in_t   src_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output pkmp_pkg::pkmp_out_t  res_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int W = pkmp_pkg::VALUE_BITS;

    logic                 busy_reg, busy_next;
    logic                 res_valid_reg, res_valid_next;
    logic [W-1:0]         prime_reg;
    logic [W-1:0]         key_reg;
    logic                 bz_reg;
    logic                 src_take;
    logic                 res_take;
    logic                 cfg_write;
    logic [W-1:0]         core_key;
    pkmp_pkg::pkmp_ctrl_t ctrl;
    pkmp_pkg::pkmp_stat_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign src_take  = src_valid && !src_stall;
    assign res_take  = res_valid_reg && !res_stall;
    assign src_stall = busy_reg;
    assign ctrl.start = src_take;

    // register read
    always_comb
    begin
        unique case (paddr[3])
            pkmp_pkg::REG_PRIME: prdata = {1'b0, prime_reg};
            default:             prdata = '0;
        endcase
    end

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= pkmp_pkg::PRIME_RESET;
        end
        else if (cfg_write && (paddr[3] == pkmp_pkg::REG_PRIME))
        begin
            prime_reg <= pwdata[W-1:0];
        end
    end

    // request and result occupancy
    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        if (src_take)
        begin
            busy_next = 1'b1;
        end
        if (stat.done)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_take)
        begin
            res_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            bz_reg <= (src_data.u == '0) && (src_data.v == '0);
        end
        if (stat.done)
        begin
            key_reg <= core_key;
        end
    end

    pkmp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .u     (src_data.u),
        .v     (src_data.v),
        .m     (prime_reg),
        .stat  (stat),
        .key   (core_key)
    );

    assign res_valid          = res_valid_reg;
    assign res_data.key       = key_reg;
    assign res_data.both_zero = bz_reg;

    // the core finishes only for an open request with no result pending
    a_done_open: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> busy_reg && !res_valid_reg)
        else $error("core result without an open request");

    // a result belongs to an open request
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> busy_reg)
        else $error("result valid while not busy");

    // the core is idle whenever no request is open
    a_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !stat.busy)
        else $error("core running with no open request");

endmodule

// ===== design/pkmp_core.sv =====
// ----------------------------------------------------------------------------
// pkmp_core
// Sequencer around one shift/subtract unit: reduces v modulo m, runs the
// extended Euclidean algorithm on (u, m) and multiplies by double and add.
// ----------------------------------------------------------------------------
module pkmp_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pkmp_pkg::pkmp_ctrl_t              ctrl,
    input  logic [pkmp_pkg::VALUE_BITS-1:0]   u,
    input  logic [pkmp_pkg::VALUE_BITS-1:0]   v,
    input  logic [pkmp_pkg::VALUE_BITS-1:0]   m,
    output pkmp_pkg::pkmp_stat_t              stat,
    output logic [pkmp_pkg::VALUE_BITS-1:0]   key
);

    localparam int W  = pkmp_pkg::VALUE_BITS;
    localparam int SW = W + 1;
    localparam int KW = $clog2(W);

    pkmp_pkg::pkmp_state_t state_reg, state_next;

    logic [W-1:0]  r0_reg, r0_next;
    logic [W-1:0]  r1_reg, r1_next;
    logic [W-1:0]  d_reg, d_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  q_reg, q_next;
    logic [SW-1:0] s0_reg, s0_next;
    logic [SW-1:0] s1_reg, s1_next;
    logic [SW-1:0] e_reg, e_next;
    logic          vred_reg, vred_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  u_reg, u_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  key_reg, key_next;

    // shared shift/subtract unit
    logic [W:0]    d2;
    logic          fits;
    logic          ge;
    logic [W-1:0]  r0_sub;
    logic [W-1:0]  q_sh;
    // sign fix of the bezout coefficient
    logic [SW-1:0] mag;
    logic          over_m;
    logic [W-1:0]  inv;
    // double and add step
    logic [W:0]    acc_sum;
    logic [W-1:0]  acc_step;
    logic [W:0]    a_dbl;
    logic [W-1:0]  a_step;

    always_comb
    begin
        d2       = {d_reg, 1'b0};
        fits     = d2 <= {1'b0, r0_reg};
        ge       = d_reg <= r0_reg;
        r0_sub   = ge ? (r0_reg - d_reg) : r0_reg;
        q_sh     = {q_reg[W-2:0], ge};
        mag      = s0_reg[W] ? (~s0_reg + SW'(1)) : s0_reg;
        over_m   = s0_reg >= {1'b0, m_reg};
        inv      = (neg_reg && (s0_reg != '0)) ? (m_reg - s0_reg[W-1:0]) : s0_reg[W-1:0];
        acc_sum  = {1'b0, acc_reg} + {1'b0, a_reg};
        acc_step = (acc_sum >= {1'b0, m_reg}) ? W'(acc_sum - {1'b0, m_reg}) : acc_sum[W-1:0];
        a_dbl    = {a_reg, 1'b0};
        a_step   = (a_dbl >= {1'b0, m_reg}) ? W'(a_dbl - {1'b0, m_reg}) : a_dbl[W-1:0];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pkmp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        d_reg    <= d_next;
        k_reg    <= k_next;
        q_reg    <= q_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        e_reg    <= e_next;
        vred_reg <= vred_next;
        neg_reg  <= neg_next;
        a_reg    <= a_next;
        acc_reg  <= acc_next;
        u_reg    <= u_next;
        m_reg    <= m_next;
        key_reg  <= key_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        q_next     = q_reg;
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        e_next     = e_reg;
        vred_next  = vred_reg;
        neg_next   = neg_reg;
        a_next     = a_reg;
        acc_next   = acc_reg;
        u_next     = u_reg;
        m_next     = m_reg;
        key_next   = key_reg;

        unique case (state_reg)
            pkmp_pkg::ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    u_next = u;
                    m_next = m;
                    if (u == '0)
                    begin
                        key_next   = m;
                        state_next = pkmp_pkg::ST_FIN;
                    end
                    else if (m == '0)
                    begin
                        key_next   = '0;
                        state_next = pkmp_pkg::ST_FIN;
                    end
                    else
                    begin
                        // first pass of the divider reduces v modulo m
                        r0_next    = v;
                        d_next     = m;
                        k_next     = '0;
                        q_next     = '0;
                        vred_next  = 1'b1;
                        state_next = pkmp_pkg::ST_ALIGN;
                    end
                end
            end

            // shift the divisor up under the dividend
            pkmp_pkg::ST_ALIGN:
            begin
                if (fits)
                begin
                    d_next = d2[W-1:0];
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    state_next = pkmp_pkg::ST_SUB;
                end
            end

            // one quotient bit per cycle, remainder left in r0
            pkmp_pkg::ST_SUB:
            begin
                r0_next = r0_sub;
                q_next  = q_sh;
                if (k_reg == '0)
                begin
                    if (vred_reg)
                    begin
                        a_next     = r0_sub;
                        r0_next    = u_reg;
                        r1_next    = m_reg;
                        d_next     = m_reg;
                        s0_next    = SW'(1);
                        s1_next    = '0;
                        q_next     = '0;
                        vred_next  = 1'b0;
                        state_next = pkmp_pkg::ST_ALIGN;
                    end
                    else
                    begin
                        e_next     = s1_reg;
                        state_next = pkmp_pkg::ST_MULS;
                    end
                end
                else
                begin
                    d_next = d_reg >> 1;
                    k_next = k_reg - KW'(1);
                end
            end

            // s0 -= q * s1, shift and subtract modulo 2^SW
            pkmp_pkg::ST_MULS:
            begin
                if (q_reg == '0)
                begin
                    state_next = pkmp_pkg::ST_SWAP;
                end
                else
                begin
                    if (q_reg[0])
                    begin
                        s0_next = s0_reg - e_reg;
                    end
                    e_next = {e_reg[SW-2:0], 1'b0};
                    q_next = q_reg >> 1;
                end
            end

            // rotate the euclid pairs
            pkmp_pkg::ST_SWAP:
            begin
                r0_next = r1_reg;
                r1_next = r0_reg;
                s0_next = s1_reg;
                s1_next = s0_reg;
                if (r0_reg == '0)
                begin
                    state_next = pkmp_pkg::ST_FIXS;
                end
                else
                begin
                    d_next     = r0_reg;
                    k_next     = '0;
                    q_next     = '0;
                    state_next = pkmp_pkg::ST_ALIGN;
                end
            end

            // split the coefficient into sign and magnitude
            pkmp_pkg::ST_FIXS:
            begin
                neg_next   = s0_reg[W];
                s0_next    = mag;
                state_next = pkmp_pkg::ST_FIXR;
            end

            // bring the magnitude below m, then fold the sign
            pkmp_pkg::ST_FIXR:
            begin
                if (over_m)
                begin
                    s0_next = s0_reg - {1'b0, m_reg};
                end
                else
                begin
                    q_next     = inv;
                    acc_next   = '0;
                    state_next = pkmp_pkg::ST_MMUL;
                end
            end

            // double and add over the bits of the inverse
            pkmp_pkg::ST_MMUL:
            begin
                if (q_reg == '0)
                begin
                    key_next   = acc_reg;
                    state_next = pkmp_pkg::ST_FIN;
                end
                else
                begin
                    if (q_reg[0])
                    begin
                        acc_next = acc_step;
                    end
                    a_next = a_step;
                    q_next = q_reg >> 1;
                end
            end

            pkmp_pkg::ST_FIN:
            begin
                state_next = pkmp_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = pkmp_pkg::ST_IDLE;
            end
        endcase
    end

    assign stat.busy = state_reg != pkmp_pkg::ST_IDLE;
    assign stat.done = state_reg == pkmp_pkg::ST_FIN;
    assign key       = key_reg;

    // a new request only reaches an idle sequencer
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == pkmp_pkg::ST_IDLE)
        else $error("start while the sequencer is busy");

    // the divider never aligns a zero divisor
    a_align_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pkmp_pkg::ST_ALIGN |-> d_reg != '0)
        else $error("zero divisor in the alignment loop");

    // modular multiply operands stay reduced
    a_mmul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pkmp_pkg::ST_MMUL |-> (acc_reg < m_reg) && (a_reg < m_reg))
        else $error("multiply operand not reduced");

    // the finish state lasts one cycle
    a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pkmp_pkg::ST_FIN |=> state_reg == pkmp_pkg::ST_IDLE)
        else $error("finish state held");

endmodule

// ===== verif/projective_key_mod_prime_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projective_key_mod_prime_tb
// Self-checking bench for the projective key block. A stimulus table covers
// the corner cases (zero entries, entries at and above the modulus, multiples
// of the modulus, modulus 0, 1, 2 and the largest 63-bit values). It is
// followed by random phases under several moduli. An in-bench extended Euclid
// and double-and-add multiply predict each key the table does not give, and
// results are checked in order, with random request bursts and result stalls.
// ----------------------------------------------------------------------------
module projective_key_mod_prime_tb;

    typedef logic [pkmp_pkg::VALUE_BITS-1:0] val_t;

    typedef enum bit {
        ROW_REQ,
        ROW_MOD
    } row_kind_t;

    // one line of the directed table; for ROW_MOD the u field carries the modulus
    typedef struct packed {
        row_kind_t kind;
        val_t      u;
        val_t      v;
        bit        known;
        val_t      key;
        bit        both_zero;
    } dir_row_t;

    localparam val_t MAXV = '1;
    localparam val_t P63  = 63'h7FFF_FFFF_FFFF_FFE7;   // largest prime below 2^63
    localparam val_t M61  = 63'h1FFF_FFFF_FFFF_FFFF;   // 2^61 - 1
    localparam int   N_DIR = 27;
    localparam int   N_PHASE = 10;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                src_valid;
    logic                src_stall;
    pkmp_pkg::pkmp_in_t  src_data;
    logic                res_valid;
    logic                res_stall = 1'b0;
    pkmp_pkg::pkmp_out_t res_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    pkmp_pkg::pkmp_out_t pending_keys [$];
    pkmp_pkg::pkmp_out_t oldest_key;
    val_t                cur_mod;
    int                  n_err;
    int                  burst_left;
    int                  stall_hold;
    int                  stall_mode;

    projective_key_mod_prime u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // first Bezout coefficient of (a, m), reduced into 0..m-1; m nonzero
    function automatic val_t euclid_inverse(input logic [63:0] a, input logic [63:0] m);
        logic [63:0] r0, r1, r2, s0, s1, s2, q, mag;
        r0 = a;
        r1 = m;
        s0 = 64'd1;
        s1 = 64'd0;
        while (r1 != 64'd0)
        begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            s2 = s0 - q * s1;
            r0 = r1;
            r1 = r2;
            s0 = s1;
            s1 = s2;
        end
        if (s0[63])
        begin
            mag = (~s0 + 64'd1) % m;
            return (mag == 64'd0) ? '0 : val_t'(m - mag);
        end
        return val_t'(s0 % m);
    endfunction

    // (a * b) mod m by double and add; m nonzero
    function automatic val_t mul_modulo(input logic [63:0] a, input logic [63:0] b,
                                        input logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd0;
        a = a % m;
        b = b % m;
        while (b != 64'd0)
        begin
            if (b[0])
            begin
                acc = acc + a;
                if (acc >= m)
                    acc = acc - m;
            end
            a = a + a;
            if (a >= m)
                a = a - m;
            b = b >> 1;
        end
        return val_t'(acc);
    endfunction

    // expected result for one request under the current modulus
    function automatic pkmp_pkg::pkmp_out_t projective_key(input pkmp_pkg::pkmp_in_t d);
        pkmp_pkg::pkmp_out_t r;
        if (d.u == '0)
            r.key = cur_mod;
        else if (cur_mod == '0)
            r.key = '0;
        else
            r.key = mul_modulo({1'b0, d.v}, {1'b0, euclid_inverse({1'b0, d.u}, {1'b0, cur_mod})},
                               {1'b0, cur_mod});
        r.both_zero = (d.u == '0) && (d.v == '0);
        return r;
    endfunction

    function automatic val_t rand_val();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[pkmp_pkg::VALUE_BITS-1:0];
    endfunction

    // send one request in bursts with random gaps; queue its expected key
    task automatic send_request(input pkmp_pkg::pkmp_in_t d, input bit known,
                                input pkmp_pkg::pkmp_out_t typed);
        if (burst_left == 0)
        begin
            src_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(100, 800)) @(posedge clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        src_valid <= 1'b1;
        src_data  <= d;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        burst_left--;
        pending_keys.push_back(known ? typed : projective_key(d));
    endtask

    // stop sending and wait for every pending key
    task automatic drain_requests();
        src_valid <= 1'b0;
        burst_left = 0;
        while (pending_keys.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb read of the modulus register, compared with the expected value
    task automatic check_modulus(input val_t want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {pkmp_pkg::REG_PRIME, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[pkmp_pkg::VALUE_BITS-1:0] !== want)
        begin
            $display("%0t: modulus readback mismatch, expected %0d, actual %0d",
                     $time, want, prdata[pkmp_pkg::VALUE_BITS-1:0]);
            n_err++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // apb write of the modulus register while the block is idle
    task automatic set_modulus(input val_t m);
        drain_requests();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {pkmp_pkg::REG_PRIME, 3'b000};
        pwdata  <= {1'b0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_mod = m;
        @(posedge clk);
        check_modulus(m);
    endtask

    // result side: in-order compare and a changing stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_keys.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual key %0d zero %0d",
                             $time, res_data.key, res_data.both_zero);
                    n_err++;
                end
                else
                begin
                    oldest_key = pending_keys.pop_front();
                    if (res_data.key !== oldest_key.key)
                    begin
                        $display("%0t: key mismatch, expected %0d, actual %0d",
                                 $time, oldest_key.key, res_data.key);
                        n_err++;
                    end
                    if (res_data.both_zero !== oldest_key.both_zero)
                    begin
                        $display("%0t: both_zero mismatch, expected %0d, actual %0d",
                                 $time, oldest_key.both_zero, res_data.both_zero);
                        n_err++;
                    end
                end
            end
            if (stall_hold == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_hold = $urandom_range(5, 60);
            end
            else
                stall_hold--;
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= $urandom_range(0, 1);
                2: res_stall <= ($urandom_range(0, 7) != 0);
                default: res_stall <= 1'b1;
            endcase
        end
    end

    // stimulus
    initial
    begin
        dir_row_t            dir_tab [N_DIR];
        val_t                phase_mod [N_PHASE];
        pkmp_pkg::pkmp_in_t  req;
        pkmp_pkg::pkmp_out_t typed;
        int                  n_items;

        src_valid <= 1'b0;
        src_data  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        n_err      = 0;
        burst_left = 0;
        stall_hold = 0;
        stall_mode = 0;
        cur_mod    = pkmp_pkg::PRIME_RESET;

        dir_tab = '{
            // reset modulus 2
            '{ROW_REQ, 63'd0,   63'd0,   1'b1, 63'd2, 1'b1},
            '{ROW_REQ, 63'd0,   MAXV,    1'b1, 63'd2, 1'b0},
            '{ROW_REQ, MAXV,    MAXV,    1'b1, 63'd1, 1'b0},
            '{ROW_REQ, 63'd2,   63'd5,   1'b1, 63'd0, 1'b0},
            // largest prime
            '{ROW_MOD, P63,     63'd0,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, 63'd1,   MAXV,    1'b0, 63'd0, 1'b0},
            '{ROW_REQ, P63,     63'd7,   1'b1, 63'd0, 1'b0},
            '{ROW_REQ, 63'd0,   63'd0,   1'b1, P63,   1'b1},
            '{ROW_REQ, P63-1,   63'd1,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, MAXV,    MAXV,    1'b0, 63'd0, 1'b0},
            '{ROW_REQ, 63'd0,   63'd5,   1'b1, P63,   1'b0},
            '{ROW_REQ, 63'd12345, 63'd0, 1'b1, 63'd0, 1'b0},
            // all-ones modulus, composite
            '{ROW_MOD, MAXV,    63'd0,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, 63'd7,   63'd1,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, MAXV,    63'd3,   1'b1, 63'd0, 1'b0},
            '{ROW_REQ, 63'd0,   MAXV,    1'b1, MAXV,  1'b0},
            // modulus of one
            '{ROW_MOD, 63'd1,   63'd0,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, 63'd5,   63'd9,   1'b1, 63'd0, 1'b0},
            '{ROW_REQ, 63'd0,   63'd3,   1'b1, 63'd1, 1'b0},
            // modulus of zero
            '{ROW_MOD, 63'd0,   63'd0,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, 63'd5,   63'd9,   1'b1, 63'd0, 1'b0},
            '{ROW_REQ, 63'd0,   63'd0,   1'b1, 63'd0, 1'b1},
            '{ROW_REQ, 63'd0,   63'd4,   1'b1, 63'd0, 1'b0},
            // mersenne prime 2^61 - 1
            '{ROW_MOD, M61,     63'd0,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, 63'd2,   63'd1,   1'b0, 63'd0, 1'b0},
            '{ROW_REQ, 63'd1,   63'd0,   1'b1, 63'd0, 1'b0},
            '{ROW_REQ, 63'd3,   MAXV,    1'b0, 63'd0, 1'b0}
        };

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        check_modulus(pkmp_pkg::PRIME_RESET);

        // directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_MOD)
                set_modulus(dir_tab[i].u);
            else
            begin
                req.u = dir_tab[i].u;
                req.v = dir_tab[i].v;
                typed.key       = dir_tab[i].key;
                typed.both_zero = dir_tab[i].both_zero;
                send_request(req, dir_tab[i].known, typed);
            end
        end

        // random phases, one modulus each
        phase_mod = '{P63, M61, rand_val() | 63'd1, 63'd3, val_t'($urandom_range(2, 255)),
                      MAXV, 63'd1000003, 63'd1, 63'd0, 63'd2};
        typed = '0;
        foreach (phase_mod[p])
        begin
            set_modulus(phase_mod[p]);
            n_items = (phase_mod[p] < 63'd2) ? 20 : 50;
            repeat (n_items)
            begin
                case ($urandom_range(0, 9))
                    0: req.u = '0;
                    1: req.u = phase_mod[p] * val_t'($urandom_range(1, 3));
                    2: req.u = val_t'($urandom_range(1, 1000));
                    3: req.u = $urandom_range(0, 1) ? phase_mod[p] - 63'd1
                                                    : phase_mod[p] + 63'd1;
                    default: req.u = rand_val();
                endcase
                case ($urandom_range(0, 9))
                    0: req.v = '0;
                    1: req.v = val_t'($urandom_range(1, 1000));
                    default: req.v = rand_val();
                endcase
                send_request(req, 1'b0, typed);
            end
        end

        // wrap up
        drain_requests();
        repeat (50) @(posedge clk);
        if (n_err == 0)
            $display("projective_key_mod_prime_tb passed");
        else
            $display("projective_key_mod_prime_tb failed");
        $finish;
    end

    // run limit
    initial
    begin
        #100_000_000;
        $display("projective_key_mod_prime_tb failed");
        $finish;
    end

endmodule
